### rtl/chg_pkg.sv
// Shared types and sizes for the convex hull (Graham scan) unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
package chg_pkg;
  localparam int MAX_POINTS = 64;
  localparam int CW         = 16;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DW         = CW + 1;
  localparam int PW         = 2 * DW;
  localparam int SW         = PW + 1;
  localparam int JOB_DEPTH  = 2;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } pt_t;

  typedef struct packed {
    cnt_t n;
    logic ovf;
  } job_t;

  typedef struct packed {
    logic done;
    logic pos;
    logic zero;
    logic closer;
  } geo_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ANC_A, ST_ANC_B, ST_CPY_INIT, ST_CPY_A, ST_CPY_B,
    ST_SRT_I, ST_SRT_V, ST_SRT_J, ST_SRT_U, ST_SRT_W,
    ST_COL_0, ST_COL_1, ST_COL_A, ST_COL_B, ST_COL_W,
    ST_SCN_A, ST_SCN_B, ST_SCN_C, ST_SCN_W, ST_SCN_P,
    ST_EMT_A, ST_EMT_B
  } bst_t;
endpackage

### rtl/chg_geom.sv
// Orientation and distance unit: sign of the cross product and squared
// distance compare, three register stages. Depends on chg_pkg.
`timescale 1ns / 1ps
module chg_geom (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  chg_pkg::pt_t o,
  input  chg_pkg::pt_t a,
  input  chg_pkg::pt_t b,
  output chg_pkg::geo_t res
);
  import chg_pkg::*;

  logic signed [DW-1:0] dax_r, day_r, dbx_r, dby_r;
  logic signed [PW-1:0] p1_r, p2_r, p3_r, p4_r, p5_r, p6_r;
  logic signed [SW-1:0] c_r, da_r, db_r;
  logic v1_r, v2_r, v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    dax_r <= {a.x[CW-1], a.x} - {o.x[CW-1], o.x};
    day_r <= {a.y[CW-1], a.y} - {o.y[CW-1], o.y};
    dbx_r <= {b.x[CW-1], b.x} - {o.x[CW-1], o.x};
    dby_r <= {b.y[CW-1], b.y} - {o.y[CW-1], o.y};
    p1_r  <= dax_r * dby_r;
    p2_r  <= dbx_r * day_r;
    p3_r  <= dax_r * dax_r;
    p4_r  <= day_r * day_r;
    p5_r  <= dbx_r * dbx_r;
    p6_r  <= dby_r * dby_r;
    c_r   <= {p1_r[PW-1], p1_r} - {p2_r[PW-1], p2_r};
    da_r  <= {p3_r[PW-1], p3_r} + {p4_r[PW-1], p4_r};
    db_r  <= {p5_r[PW-1], p5_r} + {p6_r[PW-1], p6_r};
  end

  assign res.done   = v3_r;
  assign res.zero   = (c_r == '0);
  assign res.pos    = !c_r[SW-1] && (c_r != '0);
  assign res.closer = (da_r < db_r);
endmodule

### rtl/chg_front.sv
// Front end: takes points into the point store, counts them, marks overflow
// and queues one job per set. Depends on chg_pkg.
`timescale 1ns / 1ps
module chg_front (
  input  logic          clk,
  input  logic          rst_n,
  input  chg_pkg::pt_t  pt,
  input  logic          last,
  input  logic          push,
  output logic          full,
  input  chg_pkg::addr_t rd_addr,
  output chg_pkg::pt_t  rd_data,
  input  logic          job_pop,
  output logic          job_valid,
  output chg_pkg::job_t job,
  input  logic          store_free
);
  import chg_pkg::*;

  pt_t  mem [MAX_POINTS];
  cnt_t count_r, count_nxt;
  logic ovf_r, ovf_nxt;
  logic lock_r;
  job_t q_r [JOB_DEPTH];
  logic wp_r, rp_r;
  logic [1:0] qn_r;
  logic accept, has_room;

  assign full      = lock_r || (qn_r == 2'(JOB_DEPTH));
  assign accept    = push && !full;
  assign has_room  = (count_r < cnt_t'(MAX_POINTS));
  assign count_nxt = has_room ? count_r + cnt_t'(1) : count_r;
  assign ovf_nxt   = ovf_r || !has_room;
  assign job_valid = (qn_r != 2'd0);
  assign job       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (accept && has_room) begin
      mem[count_r[ADDR_W-1:0]] <= pt;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      q_r[wp_r] <= '{n: count_nxt, ovf: ovf_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      lock_r  <= 1'b0;
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
      qn_r    <= 2'd0;
    end else begin
      if (accept) begin
        count_r <= last ? '0 : count_nxt;
        ovf_r   <= last ? 1'b0 : ovf_nxt;
      end
      if (accept && last) begin
        lock_r <= 1'b1;
        wp_r   <= ~wp_r;
      end else if (store_free) begin
        lock_r <= 1'b0;
      end
      if (job_pop && job_valid) begin
        rp_r <= ~rp_r;
      end
      qn_r <= qn_r + 2'(accept && last) - 2'(job_pop && job_valid);
    end
  end
endmodule

### rtl/chg_back.sv
// Back end: anchor search, angular sort, collinear collapse, stack scan and
// hull output. Holds the work list and hull stack. Depends on chg_pkg, chg_geom.
`timescale 1ns / 1ps
module chg_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    job_valid,
  input  chg_pkg::job_t           job,
  output logic                    job_pop,
  output chg_pkg::addr_t          pt_addr,
  input  chg_pkg::pt_t            pt_data,
  output logic                    store_free,
  output logic [chg_pkg::CW-1:0]  hull_x,
  output logic [chg_pkg::CW-1:0]  hull_y,
  output logic                    hull_last,
  output logic                    overflowed,
  output logic                    empty,
  input  logic                    pop
);
  import chg_pkg::*;

  bst_t state_r, state_nxt;
  pt_t  work [MAX_POINTS];
  pt_t  stk  [MAX_POINTS];
  pt_t  wr_q, st_q;
  cnt_t n_r, i_r, j_r, k_r, w_r, e_r, h_r;
  logic ovf_r;
  pt_t  p0_r, v_r, u_r, cw_r, t1_r, t2_r;

  logic  w_we, s_we;
  addr_t w_wa, w_ra, s_wa, s_ra;
  pt_t   w_wd, s_wd;

  logic  g_start;
  pt_t   g_o, g_a, g_b;
  geo_t  g;
  logic  gb, anc_less, slot, out_v_r;

  chg_geom u_geom (
    .clk  (clk),
    .rst_n(rst_n),
    .start(g_start),
    .o    (g_o),
    .a    (g_a),
    .b    (g_b),
    .res  (g)
  );

  assign gb       = g.pos || (g.zero && g.closer);
  assign anc_less = (pt_data.y < p0_r.y) || ((pt_data.y == p0_r.y) && (pt_data.x < p0_r.x));
  assign slot     = !out_v_r || pop;
  assign empty    = !out_v_r;

  always_ff @(posedge clk) begin
    if (w_we) begin
      work[w_wa] <= w_wd;
    end
    wr_q <= work[w_ra];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      stk[s_wa] <= s_wd;
    end
    st_q <= stk[s_ra];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (job_valid) state_nxt = ST_ANC_A;
      ST_ANC_A:    state_nxt = ST_ANC_B;
      ST_ANC_B:    state_nxt = (i_r + cnt_t'(1) == n_r) ? ST_CPY_INIT : ST_ANC_A;
      ST_CPY_INIT: state_nxt = ST_CPY_A;
      ST_CPY_A:    state_nxt = ST_CPY_B;
      ST_CPY_B:    state_nxt = (i_r + cnt_t'(1) == n_r) ? ST_SRT_I : ST_CPY_A;
      ST_SRT_I: begin
        if (i_r >= k_r) state_nxt = (k_r > cnt_t'(2)) ? ST_COL_0 : ST_SCN_A;
        else state_nxt = ST_SRT_V;
      end
      ST_SRT_V:    state_nxt = ST_SRT_J;
      ST_SRT_J:    state_nxt = (j_r == cnt_t'(1)) ? ST_SRT_I : ST_SRT_U;
      ST_SRT_U:    state_nxt = ST_SRT_W;
      ST_SRT_W:    if (g.done) state_nxt = gb ? ST_SRT_J : ST_SRT_I;
      ST_COL_0:    state_nxt = ST_COL_1;
      ST_COL_1:    state_nxt = ST_COL_A;
      ST_COL_A:    state_nxt = (i_r >= k_r) ? ST_SCN_A : ST_COL_B;
      ST_COL_B:    state_nxt = ST_COL_W;
      ST_COL_W:    if (g.done) state_nxt = ST_COL_A;
      ST_SCN_A:    state_nxt = (i_r >= k_r) ? ST_EMT_A : ST_SCN_B;
      ST_SCN_B:    state_nxt = ST_SCN_C;
      ST_SCN_C:    state_nxt = (j_r < cnt_t'(2)) ? ST_SCN_A : ST_SCN_W;
      ST_SCN_W: begin
        if (g.done) begin
          if (g.pos) state_nxt = ST_SCN_A;
          else state_nxt = (j_r >= cnt_t'(3)) ? ST_SCN_P : ST_SCN_C;
        end
      end
      ST_SCN_P:    state_nxt = ST_SCN_C;
      ST_EMT_A:    state_nxt = ST_EMT_B;
      ST_EMT_B:    if (slot) state_nxt = (e_r + cnt_t'(1) == h_r) ? ST_IDLE : ST_EMT_A;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    job_pop    = 1'b0;
    store_free = 1'b0;
    pt_addr    = i_r[ADDR_W-1:0];
    w_we       = 1'b0;
    w_wa       = '0;
    w_wd       = v_r;
    w_ra       = i_r[ADDR_W-1:0];
    s_we       = 1'b0;
    s_wa       = j_r[ADDR_W-1:0];
    s_wd       = v_r;
    s_ra       = e_r[ADDR_W-1:0];
    g_start    = 1'b0;
    g_o        = p0_r;
    g_a        = v_r;
    g_b        = wr_q;
    unique case (state_r)
      ST_IDLE:     job_pop = job_valid;
      ST_CPY_INIT: begin
        w_we = 1'b1;
        w_wd = p0_r;
      end
      ST_CPY_B: begin
        w_we       = (pt_data != p0_r);
        w_wa       = k_r[ADDR_W-1:0];
        w_wd       = pt_data;
        store_free = (i_r + cnt_t'(1) == n_r);
      end
      ST_SRT_J: begin
        w_ra = ADDR_W'(j_r - cnt_t'(1));
        w_we = (j_r == cnt_t'(1));
        w_wa = j_r[ADDR_W-1:0];
      end
      ST_SRT_U:    g_start = 1'b1;
      ST_SRT_W: begin
        w_we = g.done;
        w_wa = j_r[ADDR_W-1:0];
        w_wd = gb ? u_r : v_r;
      end
      ST_COL_0:    w_ra = addr_t'(1);
      ST_COL_B: begin
        g_start = 1'b1;
        g_a     = cw_r;
      end
      ST_COL_W: begin
        w_we = g.done;
        w_wa = g.zero ? w_r[ADDR_W-1:0] : ADDR_W'(w_r + cnt_t'(1));
      end
      ST_SCN_C: begin
        s_we    = (j_r < cnt_t'(2));
        g_start = (j_r >= cnt_t'(2));
        g_o     = t2_r;
        g_a     = t1_r;
        g_b     = v_r;
      end
      ST_SCN_W: begin
        s_we = g.done && g.pos;
        s_ra = ADDR_W'(j_r - cnt_t'(3));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        n_r   <= job.n;
        ovf_r <= job.ovf;
        i_r   <= '0;
      end
      ST_ANC_B: begin
        if ((i_r == '0) || anc_less) p0_r <= pt_data;
        i_r <= i_r + cnt_t'(1);
      end
      ST_CPY_INIT: begin
        k_r <= cnt_t'(1);
        i_r <= '0;
      end
      ST_CPY_B: begin
        if (pt_data != p0_r) k_r <= k_r + cnt_t'(1);
        i_r <= (i_r + cnt_t'(1) == n_r) ? cnt_t'(2) : i_r + cnt_t'(1);
      end
      ST_SRT_I: begin
        if ((i_r >= k_r) && (k_r <= cnt_t'(2))) begin
          i_r <= '0;
          j_r <= '0;
        end
      end
      ST_SRT_V: begin
        v_r <= wr_q;
        j_r <= i_r;
      end
      ST_SRT_J:    if (j_r == cnt_t'(1)) i_r <= i_r + cnt_t'(1);
      ST_SRT_U:    u_r <= wr_q;
      ST_SRT_W: begin
        if (g.done) begin
          if (gb) j_r <= j_r - cnt_t'(1);
          else i_r <= i_r + cnt_t'(1);
        end
      end
      ST_COL_1: begin
        cw_r <= wr_q;
        i_r  <= cnt_t'(2);
        w_r  <= cnt_t'(1);
      end
      ST_COL_A: begin
        if (i_r >= k_r) begin
          k_r <= w_r + cnt_t'(1);
          i_r <= '0;
          j_r <= '0;
        end
      end
      ST_COL_B:    v_r <= wr_q;
      ST_COL_W: begin
        if (g.done) begin
          if (!g.zero) w_r <= w_r + cnt_t'(1);
          cw_r <= v_r;
          i_r  <= i_r + cnt_t'(1);
        end
      end
      ST_SCN_A: begin
        if (i_r >= k_r) begin
          h_r <= j_r;
          e_r <= '0;
        end
      end
      ST_SCN_B:    v_r <= wr_q;
      ST_SCN_C: begin
        if (j_r < cnt_t'(2)) begin
          t2_r <= t1_r;
          t1_r <= v_r;
          j_r  <= j_r + cnt_t'(1);
          i_r  <= i_r + cnt_t'(1);
        end
      end
      ST_SCN_W: begin
        if (g.done) begin
          if (g.pos) begin
            t2_r <= t1_r;
            t1_r <= v_r;
            j_r  <= j_r + cnt_t'(1);
            i_r  <= i_r + cnt_t'(1);
          end else begin
            j_r  <= j_r - cnt_t'(1);
            t1_r <= t2_r;
          end
        end
      end
      ST_SCN_P:    t2_r <= st_q;
      ST_EMT_B:    if (slot) e_r <= e_r + cnt_t'(1);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if ((state_r == ST_EMT_B) && slot) begin
      out_v_r <= 1'b1;
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_EMT_B) && slot) begin
      hull_x     <= st_q.x;
      hull_y     <= st_q.y;
      hull_last  <= (e_r + cnt_t'(1) == h_r);
      overflowed <= ovf_r;
    end
  end
endmodule

### rtl/convex_hull_graham_scan_unit.sv
// Channel   Handshake    Word
// input     push / full  in_pt_x, in_pt_y, in_last_point
// result    pop / empty  out_hull_x, out_hull_y, out_hull_last, out_overflowed
// Points load one per cycle into the point store while full is low. On the last
// point of a set the back end runs anchor search, copy, insertion sort, collinear
// collapse, stack scan with its pushes and pops, and hull output; the sort compares,
// collapse steps and scan turns all use the single three-stage orientation unit.
// full rises after a last point and falls once the back end has copied the set.
// Reset (rst_n low, synchronous) empties both sides; a stalled result holds.
`timescale 1ns / 1ps
module convex_hull_graham_scan_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [chg_pkg::CW-1:0] in_pt_x,
  input  logic [chg_pkg::CW-1:0] in_pt_y,
  input  logic                   in_last_point,
  input  logic                   push,
  output logic                   full,
  output logic [chg_pkg::CW-1:0] out_hull_x,
  output logic [chg_pkg::CW-1:0] out_hull_y,
  output logic                   out_hull_last,
  output logic                   out_overflowed,
  output logic                   empty,
  input  logic                   pop
);
  import chg_pkg::*;

  pt_t   in_pt, pt_data;
  addr_t pt_addr;
  logic  job_valid, job_pop, store_free;
  job_t  job;

  assign in_pt.x = in_pt_x;
  assign in_pt.y = in_pt_y;

  chg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .pt        (in_pt),
    .last      (in_last_point),
    .push      (push),
    .full      (full),
    .rd_addr   (pt_addr),
    .rd_data   (pt_data),
    .job_pop   (job_pop),
    .job_valid (job_valid),
    .job       (job),
    .store_free(store_free)
  );

  chg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .pt_addr   (pt_addr),
    .pt_data   (pt_data),
    .store_free(store_free),
    .hull_x    (out_hull_x),
    .hull_y    (out_hull_y),
    .hull_last (out_hull_last),
    .overflowed(out_overflowed),
    .empty     (empty),
    .pop       (pop)
  );
endmodule
